// ----- hw/rtl/cfrc_pkg.sv -----
// Shared types, constants and the command decoder for the command frame receiver.
// Used by every module of the block; depends on nothing.
package cfrc_pkg;

  // Framing bytes.
  localparam logic [7:0] START_BYTE     = 8'h01;
  localparam logic [7:0] CMD_BYTE_ERASE = 8'h05;
  localparam logic [7:0] CMD_BYTE_WRITE = 8'h06;
  localparam logic [7:0] CMD_BYTE_RESET = 8'h07;
  localparam logic [7:0] CMD_BYTE_SWAP  = 8'h08;
  localparam logic [7:0] CMD_BYTE_VERIFY = 8'h0b;

  // Frame geometry.
  localparam int         INDEX_W             = 9;
  localparam logic [8:0] LEN_ERASE           = 9'd11;
  localparam logic [8:0] LEN_WRITE           = 9'd261;
  localparam logic [8:0] LEN_SHORT           = 9'd6;
  localparam logic [8:0] CMD_INDEX           = 9'd3;
  localparam logic [8:0] FIRST_PAYLOAD_INDEX = 9'd4;
  localparam logic [8:0] MAX_INDEX           = LEN_WRITE - 9'd1;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Forwarded command codes.
  typedef enum logic [2:0] {
    CMD_ERASE     = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_RESET     = 3'd2,
    CMD_SWAP_BOOT = 3'd3,
    CMD_VERIFY    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic               known;
    cmd_t               code;
    logic [INDEX_W-1:0] len;
  } cmd_decode_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    cmd_t               command;
    logic [INDEX_W-1:0] byte_index;
    logic [7:0]         data_byte;
    logic               last;
    logic [7:0]         sum;
  } cfrc_item_t;

  // Maps the command byte to its code and frame length.
  function automatic cmd_decode_t decode_command(input logic [7:0] b);
    cmd_decode_t d;
    d.known = 1'b1;
    d.code  = CMD_ERASE;
    d.len   = LEN_SHORT;
    unique case (b)
      CMD_BYTE_ERASE: begin
        d.code = CMD_ERASE;
        d.len  = LEN_ERASE;
      end
      CMD_BYTE_WRITE: begin
        d.code = CMD_WRITE;
        d.len  = LEN_WRITE;
      end
      CMD_BYTE_RESET:  d.code = CMD_RESET;
      CMD_BYTE_SWAP:   d.code = CMD_SWAP_BOOT;
      CMD_BYTE_VERIFY: d.code = CMD_VERIFY;
      default: begin
        d.known = 1'b0;
        d.len   = '0;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/cfrc_front.sv -----
// Front end: accepts received bytes, tracks frame position, length and running sum,
// and pushes payload bytes into the queue. Depends on cfrc_pkg.
module cfrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                push_ready,
  output logic                push_valid,
  output cfrc_pkg::cfrc_item_t push_item
);
  import cfrc_pkg::*;

  logic [INDEX_W-1:0] byte_count, byte_count_next;
  logic [INDEX_W-1:0] frame_length, frame_length_next;
  logic [7:0]         running_sum, running_sum_next;
  cmd_t               command_code, command_code_next;

  logic               accept;
  logic               is_last;
  logic [7:0]         sum_plus;
  cmd_decode_t        dec;

  // The front stalls only when the queue is full.
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign sum_plus = running_sum + rx_byte;
  assign dec      = decode_command(rx_byte);
  assign is_last  = ({1'b0, byte_count} + 10'd1) >= {1'b0, frame_length};

  // Payload bytes, from index four on, go to the back end.
  assign push_valid           = accept && (byte_count >= FIRST_PAYLOAD_INDEX);
  assign push_item.command    = command_code;
  assign push_item.byte_index = byte_count;
  assign push_item.data_byte  = rx_byte;
  assign push_item.last       = is_last;
  assign push_item.sum        = running_sum;

  // Frame state update for one accepted byte.
  always_comb begin
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    command_code_next = command_code;
    if (accept) begin
      priority if (byte_count == '0) begin
        if (rx_byte == START_BYTE) begin
          running_sum_next  = rx_byte;
          frame_length_next = '0;
          byte_count_next   = 9'd1;
        end
      end else if (byte_count < CMD_INDEX) begin
        running_sum_next = sum_plus;
        byte_count_next  = byte_count + 9'd1;
      end else if (byte_count == CMD_INDEX) begin
        if (dec.known) begin
          command_code_next = dec.code;
          frame_length_next = dec.len;
          running_sum_next  = sum_plus;
          byte_count_next   = FIRST_PAYLOAD_INDEX;
        end else begin
          byte_count_next   = '0;
          frame_length_next = '0;
          running_sum_next  = '0;
          command_code_next = CMD_ERASE;
        end
      end else if (is_last) begin
        byte_count_next   = '0;
        frame_length_next = '0;
        running_sum_next  = '0;
        command_code_next = CMD_ERASE;
      end else begin
        running_sum_next = sum_plus;
        byte_count_next  = byte_count + 9'd1;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      command_code <= CMD_ERASE;
    end else begin
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      command_code <= command_code_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_INDEX)
    else $error("frame position beyond the longest frame");

  a_push_known_frame: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (frame_length != '0) && (byte_count < frame_length))
    else $error("payload byte forwarded without a known frame length");

  a_bad_start_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && (byte_count == '0) && (rx_byte != START_BYTE)) |=> (byte_count == '0))
    else $error("frame opened by a byte other than the start byte");
`endif

endmodule

// ----- hw/rtl/cfrc_queue.sv -----
// Short queue that decouples the framing front end from the output back end.
// Depends on cfrc_pkg.
module cfrc_queue #(
  parameter int DEPTH = cfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  cfrc_pkg::cfrc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output cfrc_pkg::cfrc_item_t pop_item
);
  import cfrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfrc_item_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign push_ready = count < CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count above its depth");
`endif

endmodule

// ----- hw/rtl/cfrc_back.sv -----
// Back end: takes classified bytes from the queue, forms the checksum verdict on the
// last byte and holds the result in an output register. Depends on cfrc_pkg.
module cfrc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cfrc_pkg::cfrc_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           command,
  output logic [8:0]           byte_index,
  output logic [7:0]           data_byte,
  output logic                 last,
  output logic                 checksum_good
);
  import cfrc_pkg::*;

  cfrc_item_t held;
  logic       good;
  logic       load;

  // The output register refills whenever it is empty or being drained.
  assign load      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= pop_valid;
    end
  end

  // Result payload, with the verdict formed only on the last byte.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= pop_item;
      good <= pop_item.last && (pop_item.sum == pop_item.data_byte);
    end
  end

  assign command       = held.command;
  assign byte_index    = held.byte_index;
  assign data_byte     = held.data_byte;
  assign last          = held.last;
  assign checksum_good = good;

`ifndef ASSERT_OFF
  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && checksum_good) |-> last)
    else $error("good checksum verdict on a byte that is not the last");
`endif

endmodule

// ----- hw/rtl/command_frame_receiver_checksum.sv -----
// Command frame receiver: frames bootloader commands and flags the checksum verdict.
// Throughput: one received byte per clock cycle, sustained, while results are taken.
// Path: a payload byte is written into the queue at its transfer in, then loaded into the
// output register whenever that register is empty or being drained, and so reaches the output.
// Stalls: in_ready follows queue space only; with the output held off, the queue and the
// output register take QUEUE_DEPTH + 1 results before in_ready drops, header bytes too.
// Reset (synchronous): returns the framer to idle and empties queue and output register.
// Depends on cfrc_pkg, cfrc_front, cfrc_queue and cfrc_back.
module command_frame_receiver_checksum #(
  parameter int QUEUE_DEPTH = cfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] command,
  output logic [8:0] byte_index,
  output logic [7:0] data_byte,
  output logic       last,
  output logic       checksum_good
);
  import cfrc_pkg::*;

  logic       push_valid, push_ready;
  cfrc_item_t push_item;
  logic       pop_valid, pop_ready;
  cfrc_item_t pop_item;

  // Framing and classification.
  cfrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Decoupling queue.
  cfrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Verdict and output register.
  cfrc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .byte_index    (byte_index),
    .data_byte     (data_byte),
    .last          (last),
    .checksum_good (checksum_good)
  );

endmodule

// ----- verif/command_frame_receiver_checksum_test.sv -----
// Self-checking testbench for command_frame_receiver_checksum.
// Drives framed, noisy and broken byte streams and checks every forwarded byte
// against an in-bench frame predictor; depends on cfrc_pkg and the block RTL.
module command_frame_receiver_checksum_test;
  import cfrc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;

  // One forwarded byte as the block should present it.
  typedef struct {
    cmd_t       command;
    logic [8:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
    logic       checksum_good;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] command;
  logic [8:0] byte_index;
  logic [7:0] data_byte;
  logic       last;
  logic       checksum_good;

  // Framer state as predicted from the accepted bytes.
  logic [8:0] rx_pos = '0;
  logic [8:0] rx_len = '0;
  logic [7:0] rx_sum = '0;
  cmd_t       rx_cmd = CMD_ERASE;

  frame_out_t expected_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_count = 0;
  int hold_ack_count = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int good_verdicts = 0;
  int bad_verdicts = 0;
  int mismatches = 0;

  command_frame_receiver_checksum u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command      (command),
    .byte_index   (byte_index),
    .data_byte    (data_byte),
    .last         (last),
    .checksum_good(checksum_good)
  );

  always #5 clk = ~clk;

  // Frame length for a command byte; zero means the command is unknown.
  function automatic int frame_length_for(input logic [7:0] b);
    case (b)
      CMD_BYTE_ERASE:  return int'(LEN_ERASE);
      CMD_BYTE_WRITE:  return int'(LEN_WRITE);
      CMD_BYTE_RESET,
      CMD_BYTE_SWAP,
      CMD_BYTE_VERIFY: return int'(LEN_SHORT);
      default:         return 0;
    endcase
  endfunction

  // Advance the predicted framer by one accepted byte.
  task automatic predict_rx(input logic [7:0] b);
    frame_out_t item;
    if (rx_pos == 9'd0) begin
      if (b == START_BYTE) begin
        rx_sum = b;
        rx_len = '0;
        rx_pos = 9'd1;
      end
    end else if (rx_pos < CMD_INDEX) begin
      rx_sum = rx_sum + b;
      rx_pos = rx_pos + 9'd1;
    end else if (rx_pos == CMD_INDEX) begin
      if (frame_length_for(b) == 0) begin
        // Unknown command: the frame is dropped silently.
        rx_pos = '0;
        rx_len = '0;
        rx_sum = '0;
        rx_cmd = CMD_ERASE;
      end else begin
        case (b)
          CMD_BYTE_ERASE:  rx_cmd = CMD_ERASE;
          CMD_BYTE_WRITE:  rx_cmd = CMD_WRITE;
          CMD_BYTE_RESET:  rx_cmd = CMD_RESET;
          CMD_BYTE_SWAP:   rx_cmd = CMD_SWAP_BOOT;
          default:         rx_cmd = CMD_VERIFY;
        endcase
        rx_len = 9'(frame_length_for(b));
        rx_sum = rx_sum + b;
        rx_pos = FIRST_PAYLOAD_INDEX;
      end
    end else begin
      item.command    = rx_cmd;
      item.byte_index = rx_pos;
      item.data_byte  = b;
      if (int'(rx_pos) + 1 >= int'(rx_len)) begin
        // Checksum byte: verdict, then back to idle.
        item.last          = 1'b1;
        item.checksum_good = (rx_sum == b);
        rx_pos = '0;
        rx_len = '0;
        rx_sum = '0;
        rx_cmd = CMD_ERASE;
      end else begin
        item.last          = 1'b0;
        item.checksum_good = 1'b0;
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 9'd1;
      end
      expected_bytes.push_back(item);
    end
  endtask

  // Offer one byte, with random gaps before it, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    predict_rx(b);
    bytes_sent++;
  endtask

  // Send one frame. A negative fill means random header and payload bytes.
  // An unknown command byte ends the frame right after it.
  task automatic send_frame(input logic [7:0] cmd_byte, input bit good_sum, input int fill);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    int         len;
    int         i;
    len = frame_length_for(cmd_byte);
    frame_bytes.push_back(START_BYTE);
    for (i = 1; i < 3; i++)
      frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    frame_bytes.push_back(cmd_byte);
    if (len != 0) begin
      for (i = 4; i < len - 1; i++)
        frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      sum = '0;
      foreach (frame_bytes[k]) sum = sum + frame_bytes[k];
      frame_bytes.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    end
    foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req_count != hold_ack_count) begin
      hold_ack_count = hold_req_count;
      hold_left      = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each output transfer with the oldest predicted byte.
  always @(posedge clk) begin : check_outputs
    frame_out_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: unexpected output cmd=%0d idx=%0d data=%02h last=%b good=%b",
                   command, byte_index, data_byte, last, checksum_good);
      end else begin
        exp_item = expected_bytes.pop_front();
        if (command !== exp_item.command || byte_index !== exp_item.byte_index ||
            data_byte !== exp_item.data_byte || last !== exp_item.last ||
            checksum_good !== exp_item.checksum_good) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("Mismatch: expected cmd=%0d idx=%0d data=%02h last=%b good=%b,",
                   exp_item.command, exp_item.byte_index, exp_item.data_byte,
                   exp_item.last, exp_item.checksum_good);
            $display(" got cmd=%0d idx=%0d data=%02h last=%b good=%b",
                     command, byte_index, data_byte, last, checksum_good);
          end
        end
        results_checked++;
        if (exp_item.last) begin
          if (exp_item.checksum_good) good_verdicts++;
          else bad_verdicts++;
        end
      end
    end
  end

  // Bytes that are not a start byte while idle must be dropped.
  task automatic test_bad_start();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  // An unknown command drops the frame after its fourth byte.
  task automatic test_unknown_command();
    send_frame(8'h09, 1'b1, 8'hff);
  endtask

  // The three short commands with all-ones, all-zero and random payloads and both verdicts.
  task automatic test_short_frames();
    send_frame(CMD_BYTE_VERIFY, 1'b1, 8'hff);
    send_frame(CMD_BYTE_RESET, 1'b0, 8'h00);
    send_frame(CMD_BYTE_SWAP, 1'b1, -1);
  endtask

  // The erase frame with its eleven bytes.
  task automatic test_erase_frame();
    send_frame(CMD_BYTE_ERASE, 1'b1, -1);
    send_frame(CMD_BYTE_ERASE, 1'b0, 8'hff);
  endtask

  // A full write frame while the receiver holds off, so the input stalls.
  task automatic test_write_backpressure();
    hold_req_count++;
    send_frame(CMD_BYTE_WRITE, 1'b1, -1);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic test_random_traffic(input int n_bytes);
    int         stop_at;
    int         pick;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(8'($urandom));
      end else if (pick < 16) begin
        do b = 8'($urandom); while (frame_length_for(b) != 0);
        send_frame(b, 1'b1, -1);
      end else begin
        case ($urandom_range(0, 19))
          0:          b = CMD_BYTE_WRITE;
          1, 2, 3, 4: b = CMD_BYTE_ERASE;
          5, 6, 7, 8: b = CMD_BYTE_RESET;
          9, 10, 11:  b = CMD_BYTE_SWAP;
          default:    b = CMD_BYTE_VERIFY;
        endcase
        send_frame(b, $urandom_range(0, 1), -1);
      end
    end
  endtask

  initial begin : run_tests
    int drain_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 48;
    test_bad_start();
    test_unknown_command();
    test_short_frames();
    test_erase_frame();
    test_random_traffic(45);

    send_idle_pct = 48;
    recv_idle_pct = 17;
    test_random_traffic(45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_write_backpressure();
    test_random_traffic(45);

    @(negedge clk);
    in_valid = 1'b0;

    // Let the last results drain, then wait on for stragglers.
    drain_cycles = 0;
    while (expected_bytes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_bytes.size() != 0)
      $display("Missing outputs: %0d predicted bytes never arrived", expected_bytes.size());

    $display("Summary: %0d bytes sent, %0d output bytes checked, %0d mismatches.",
             bytes_sent, results_checked, mismatches);
    $display("Summary: %0d frames with good checksum, %0d with bad checksum.",
             good_verdicts, bad_verdicts);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
